// ===== src/stwd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package stwd_pkg;

  localparam int unsigned PhaseW   = 4;
  localparam int unsigned CyclesW  = 16;
  localparam int unsigned LevelW   = 8;
  localparam int unsigned SampleW  = 8;

  localparam logic [PhaseW-1:0]  PhaseLast   = 4'd15;
  localparam logic [LevelW-1:0]  FullScale   = 8'd255;
  localparam logic [LevelW-1:0]  DecayStart  = 8'd200;
  localparam logic [LevelW-1:0]  DecayLimit  = 8'd220;
  localparam logic [LevelW-1:0]  MaxStep     = 8'd5;

  // x / 50 for any 8-bit x equals (x * 41) >> 11
  localparam logic [5:0]         Div50Mul    = 6'd41;
  localparam int unsigned        Div50Shift  = 11;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_START = 1'b1
  } cmd_t;

  function automatic logic [LevelW-1:0] wave_lut(input logic [PhaseW-1:0] ph);
    logic [LevelW-1:0] v;
    case (ph)
      4'd0:    v = 8'd176;
      4'd1:    v = 8'd217;
      4'd2:    v = 8'd244;
      4'd3:    v = 8'd254;
      4'd4:    v = 8'd244;
      4'd5:    v = 8'd217;
      4'd6:    v = 8'd176;
      4'd7:    v = 8'd128;
      4'd8:    v = 8'd80;
      4'd9:    v = 8'd39;
      4'd10:   v = 8'd12;
      4'd11:   v = 8'd2;
      4'd12:   v = 8'd12;
      4'd13:   v = 8'd39;
      4'd14:   v = 8'd80;
      default: v = 8'd128;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== src/sine_tone_with_decay_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Bell tone generator with a decaying envelope.
// Input channel (in_valid / in_stall): one word per command. A start word
// (in_command = 1) loads in_start_cycles, sets full volume and rewinds the
// phase; it yields no output. A tick word (in_command = 0) yields exactly one
// output word (out_sample, out_playing) and steps the oscillator unless idle.
// Path: an accepted word is registered in the input register; a tick's
// result is then registered in the output register, where out_valid rises,
// as soon as the output register is free.
// Throughput: one word per cycle unless a stalled output holds a tick.
// The table lookup, 8x8 volume multiply and envelope update are combinational
// between the two registers and also set the next oscillator state.
// While out_stall is high the output word holds; the input register still
// drains start words, and a tick waits there, raising in_stall only when the
// output register is full and stalled.
// Reset (rst_n low, synchronous): both registers empty, phase at its last
// entry, volume, cycle count and decay envelope cleared. A tick after reset
// outputs 0 with out_playing low.
module sine_tone_with_decay_core (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire                          in_command,
  input  wire [stwd_pkg::CyclesW-1:0]  in_start_cycles,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [stwd_pkg::SampleW-1:0] out_sample,
  output logic                         out_playing
);
  import stwd_pkg::*;

  // input register
  logic               s1_valid_r, s1_valid_nxt;
  cmd_t               s1_cmd_r;
  logic [CyclesW-1:0] s1_cycles_r;

  // oscillator and envelope state
  logic [PhaseW-1:0]  phase_r, phase_nxt;
  logic [CyclesW-1:0] cycles_r, cycles_nxt;
  logic [LevelW-1:0]  amp_r, amp_nxt;
  logic [LevelW-1:0]  dcnt_r, dcnt_nxt;
  logic [LevelW-1:0]  dstep_r, dstep_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic [SampleW-1:0] out_sample_r;
  logic               out_playing_r;

  logic               out_free;
  logic               s1_fire;
  logic               s1_tick;
  logic               in_fire;
  logic [2*LevelW-1:0] prod;
  logic [SampleW-1:0] sample_val;
  logic [13:0]        div_prod;
  logic [LevelW-1:0]  amp_div50;
  logic [LevelW-1:0]  cnt_inc;
  logic [LevelW-1:0]  step_use;
  logic [LevelW-1:0]  amp_dec;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && (s1_cmd_r == CMD_START || out_free);
  assign s1_tick  = s1_fire && s1_cmd_r == CMD_TICK;
  assign in_stall = s1_valid_r && !s1_fire;
  assign in_fire  = in_valid && !in_stall;

  // product >> 8 of two 8-bit values never exceeds 254, no clamp needed
  assign prod       = wave_lut(phase_r) * amp_r;
  assign sample_val = prod[2*LevelW-1:LevelW];

  assign div_prod  = amp_r * Div50Mul;
  assign amp_div50 = {5'd0, div_prod[13:Div50Shift]};

  assign cnt_inc  = dcnt_r + 8'd1;
  assign step_use = (dstep_r == '0) ? amp_div50 : dstep_r;
  assign amp_dec  = amp_r - step_use;

  always_comb begin
    phase_nxt  = phase_r;
    cycles_nxt = cycles_r;
    amp_nxt    = amp_r;
    dcnt_nxt   = dcnt_r;
    dstep_nxt  = dstep_r;
    if (s1_fire && s1_cmd_r == CMD_START) begin
      phase_nxt  = '0;
      cycles_nxt = s1_cycles_r;
      amp_nxt    = FullScale;
      dcnt_nxt   = '0;
    end else if (s1_tick) begin
      if (phase_r != PhaseLast) begin
        phase_nxt = phase_r + 4'd1;
      end else if (cycles_r != '0) begin
        phase_nxt  = '0;
        cycles_nxt = cycles_r - 16'd1;
        dcnt_nxt   = cnt_inc;
        if (cnt_inc >= DecayStart) begin
          amp_nxt   = amp_dec;
          dstep_nxt = step_use;
          if (amp_dec <= step_use || cnt_inc >= DecayLimit) begin
            dstep_nxt = '0;
            dcnt_nxt  = '0;
          end
        end
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_tick) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PhaseLast;
      cycles_r    <= '0;
      amp_r       <= '0;
      dcnt_r      <= '0;
      dstep_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
      cycles_r    <= cycles_nxt;
      amp_r       <= amp_nxt;
      dcnt_r      <= dcnt_nxt;
      dstep_r     <= dstep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r    <= cmd_t'(in_command);
      s1_cycles_r <= in_start_cycles;
    end
    if (s1_tick) begin
      out_sample_r  <= sample_val;
      out_playing_r <= (cycles_nxt != '0);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_sample  = out_sample_r;
  assign out_playing = out_playing_r;

  // volume only falls between starts
  a_amp_no_rise: assert property (@(posedge clk) disable iff (!rst_n)
    s1_tick |=> amp_r <= $past(amp_r))
    else $error("volume rose on a tick");

  // decay counter is cleared before it can pass the limit
  a_dcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dcnt_r < DecayLimit)
    else $error("decay counter past limit");

  // step is at most 255/50
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dstep_r <= MaxStep)
    else $error("decay step out of range");

  // idle oscillator parks on its last entry
  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_tick && phase_r == PhaseLast && cycles_r == '0 |=> phase_r == PhaseLast)
    else $error("idle phase moved");

endmodule
`default_nettype wire

// ===== bench/tb_sine_tone_with_decay_core.sv =====
`timescale 1ns / 1ps
module tb_sine_tone_with_decay_core;
  import stwd_pkg::*;

  localparam int ClkHalf     = 4;
  localparam int ResetCycles = 9;
  localparam int CycleLimit  = 4_000_000;
  localparam int TailCycles  = 16;
  localparam int ShortWords  = 700;
  localparam int LongHold    = 64;
  localparam int BurstWords  = 24;
  localparam int TableLen    = 16;
  localparam int LevelDiv    = 10;
  localparam int MaxGap      = 13;
  localparam int MaxReports  = 20;
  // below this volume the decay step comes out as zero
  localparam logic [LevelW-1:0] QuietLevel = 8'd50;

  typedef enum int {
    IDLE_FULL,
    IDLE_SPARSE,
    IDLE_NONE
  } idle_mode_t;

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               playing;
  } tone_word_t;

  class tone_scoreboard;
    logic [LevelW-1:0]  rom [TableLen];
    logic [PhaseW-1:0]  phase;
    logic [CyclesW-1:0] cycles_left;
    logic [LevelW-1:0]  level;
    logic [LevelW-1:0]  decay_count;
    logic [LevelW-1:0]  decay_step;
    logic [LevelW-1:0]  lowest_level;
    tone_word_t         pending_samples [$];
    int                 errors;
    int                 words_in;
    int                 samples_seen;
    int                 zero_step_cycles;
    int                 carried_steps;

    function new();
      rom = '{8'd176, 8'd217, 8'd244, 8'd254, 8'd244, 8'd217, 8'd176, 8'd128,
              8'd80, 8'd39, 8'd12, 8'd2, 8'd12, 8'd39, 8'd80, 8'd128};
      phase        = PhaseLast;
      cycles_left  = '0;
      level        = '0;
      decay_count  = '0;
      decay_step   = '0;
      lowest_level = FullScale;
    endfunction

    function int pending();
      return pending_samples.size();
    endfunction

    function void apply_command(cmd_t cmd, logic [CyclesW-1:0] cyc);
      logic [2*LevelW-1:0] prod;
      tone_word_t          w;
      words_in++;
      if (cmd == CMD_START) begin
        // step survives a restart on purpose
        level       = FullScale;
        decay_count = '0;
        phase       = '0;
        cycles_left = cyc;
        return;
      end
      prod = rom[phase] * level;
      w.sample = ((prod >> LevelW) > FullScale) ? FullScale : prod[2*LevelW-1:LevelW];
      if (phase != PhaseLast) begin
        phase++;
      end else if (cycles_left != '0) begin
        phase = '0;
        cycles_left--;
        decay_count++;
        if (decay_count >= DecayStart) begin
          if (decay_step == '0) begin
            decay_step = LevelW'(level / LevelDiv / MaxStep);
            if (decay_step == '0) zero_step_cycles++;
          end else if (decay_count == DecayStart) begin
            carried_steps++;
          end
          level = level - decay_step;
          if (level < lowest_level) lowest_level = level;
          if (level <= decay_step || decay_count >= DecayLimit) begin
            decay_step  = '0;
            decay_count = '0;
          end
        end
      end
      w.playing = (cycles_left != '0);
      pending_samples.push_back(w);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MaxReports) $display("ERROR: %s", msg);
    endtask

    task check_sample(logic [SampleW-1:0] s, logic p);
      tone_word_t w;
      if (pending_samples.size() == 0) begin
        report($sformatf("output word %0d/%0d with nothing outstanding", s, p));
        return;
      end
      w = pending_samples.pop_front();
      samples_seen++;
      if (s !== w.sample)
        report($sformatf("word %0d sample: got %0d want %0d", samples_seen, s, w.sample));
      if (p !== w.playing)
        report($sformatf("word %0d playing: got %0d want %0d", samples_seen, p, w.playing));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_command = 1'b0;
  logic [CyclesW-1:0] in_start_cycles = '0;
  logic               out_stall = 1'b0;
  wire                in_stall;
  wire                out_valid;
  wire [SampleW-1:0]  out_sample;
  wire                out_playing;

  tone_scoreboard sb;
  idle_mode_t     tx_mode = IDLE_FULL;
  idle_mode_t     rx_mode = IDLE_FULL;
  logic           hold_req = 1'b0;
  int             in_stall_hits = 0;
  int unsigned    cycle_count = 0;

  sine_tone_with_decay_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_start_cycles (in_start_cycles),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sample      (out_sample),
    .out_playing     (out_playing)
  );

  always #ClkHalf clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.apply_command(cmd_t'(in_command), in_start_cycles);
      if (in_valid && in_stall) in_stall_hits++;
      if (out_valid && !out_stall) sb.check_sample(out_sample, out_playing);
    end
  end

  function automatic int draw_gap(idle_mode_t m);
    int g;
    case (m)
      IDLE_FULL:   g = $urandom_range(0, MaxGap);
      IDLE_SPARSE: g = ($urandom_range(0, 15) == 0) ? $urandom_range(0, MaxGap) : 0;
      default:     g = 0;
    endcase
    return g;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(cmd_t cmd, logic [CyclesW-1:0] cyc);
    int gap;
    gap = draw_gap(tx_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_start_cycles <= cyc;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic tick();
    send_word(CMD_TICK, CyclesW'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  // result side
  initial begin
    int n;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      n = draw_gap(rx_mode);
      if (hold_req) begin
        n = LongHold;
        hold_req = 1'b0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    int               base;
    logic             restarted;
    logic [CyclesW-1:0] cyc;
    sb = new();
    repeat (ResetCycles) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ticks straight out of reset: silent, phase parked on the last entry
    tick();
    tick();
    send_word(CMD_START, '1);
    send_word(CMD_START, '0);
    // whole table, then parked at full volume with nothing left to play
    repeat (18) tick();
    send_word(CMD_START, 16'd1);

    // output held off while ticks keep coming: pipeline fills, input stalls
    hold_req = 1'b1;
    tx_mode  = IDLE_NONE;
    repeat (BurstWords) tick();
    tx_mode = IDLE_FULL;
    drain();

    // short tones, mostly a few periods, with stray words mixed in
    base = sb.words_in;
    while (sb.words_in - base < ShortWords) begin
      tx_mode = ($urandom_range(0, 4) == 0) ? IDLE_NONE : IDLE_FULL;
      rx_mode = ($urandom_range(0, 4) == 0) ? IDLE_NONE : IDLE_FULL;
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 5)) send_word(cmd_t'($urandom_range(0, 1)), CyclesW'($urandom));
      end else begin
        cyc = ($urandom_range(0, 3) == 0) ? CyclesW'($urandom) : CyclesW'($urandom_range(0, 4));
        send_word(CMD_START, cyc);
        repeat ($urandom_range(0, 90)) tick();
      end
      if ($urandom_range(0, 19) == 0) drain();
    end
    drain();

    // one long tone down through the envelope: restart mid-decay so a
    // smaller step carries over, then ride it until the step hits zero
    tx_mode = IDLE_SPARSE;
    rx_mode = IDLE_SPARSE;
    restarted = 1'b0;
    send_word(CMD_START, '1);
    while (sb.level >= QuietLevel) begin
      if (!restarted && sb.decay_step != '0 && sb.decay_step != MaxStep &&
          sb.decay_count == DecayStart + 5) begin
        send_word(CMD_START, CyclesW'($urandom_range(32768, 65535)));
        restarted = 1'b1;
      end else begin
        tick();
      end
    end
    repeat ((DecayLimit + 5) * TableLen) tick();

    drain();
    repeat (TailCycles) @(negedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d words never came out", sb.pending()));

    $display("run: %0d words in, %0d samples checked, input stalled on %0d cycles",
             sb.words_in, sb.samples_seen, in_stall_hits);
    $display("envelope: volume down to %0d, %0d zero-step periods, %0d steps kept over a restart",
             sb.lowest_level, sb.zero_step_cycles, sb.carried_steps);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sine_tone_with_decay_core.f =====
src/stwd_pkg.sv
src/sine_tone_with_decay_core.sv
bench/tb_sine_tone_with_decay_core.sv
